/* design/sbox_multiply_hash_defines.svh */
// Assertion macros used by the top-level design file
`ifndef SBOX_MULTIPLY_HASH_DEFINES_SVH
`define SBOX_MULTIPLY_HASH_DEFINES_SVH

// Implication check, cycle-relative
`define SMH_ASSERT_IMP(label, clk, rstn, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
        else $error(msg);

// Next-cycle implication check
`define SMH_ASSERT_NXT(label, clk, rstn, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

/* design/smh_pkg.sv */
`timescale 1ns / 1ps
package smh_pkg;
    localparam int WORD_W    = 64;
    localparam int ADDR_W    = 15;
    localparam int ENTRY_W   = 12;
    localparam int SEL_W     = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRIME_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRIME_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRIME_PROD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_MULT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_HASH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_VALUE   = 3'd6;

    // multiplier handshake
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] p;
    } mul_rsp_t;

    // divider handshake
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] n;
        logic [WORD_W-1:0] d;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] r;
    } div_rsp_t;
endpackage

/* design/smh_ram.sv */
`timescale 1ns / 1ps
module smh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* design/smh_mul.sv */
`timescale 1ns / 1ps
module smh_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  smh_pkg::mul_req_t req,
    output smh_pkg::mul_rsp_t rsp
);
    // 64x64 low product as three 32x32 partials, one per cycle
    logic [63:0] a_reg, b_reg, acc_reg, acc_next;
    logic [1:0]  step_reg;
    logic        busy_reg, done_reg;
    logic [31:0] pa, pb;
    logic [63:0] part;

    always_comb begin
        pa = step_reg[0] ? a_reg[63:32] : a_reg[31:0];
        pb = step_reg[1] ? b_reg[63:32] : b_reg[31:0];
        part = pa * pb;
        case (step_reg)
            2'd0:    acc_next = part;
            2'd1:    acc_next = acc_reg + {part[31:0], 32'd0};
            2'd2:    acc_next = acc_reg + {part[31:0], 32'd0};
            default: acc_next = acc_reg;
        endcase
    end

    // advance one partial product per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd2) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg <= req.a;
            b_reg <= req.b;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg;
endmodule

/* design/smh_div.sv */
`timescale 1ns / 1ps
module smh_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  smh_pkg::div_req_t req,
    output smh_pkg::div_rsp_t rsp
);
    // restoring remainder, one quotient bit per cycle
    logic [63:0] n_reg, d_reg, r_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [64:0] shifted, diff;

    always_comb begin
        shifted = {r_reg, n_reg[63]};
        diff    = shifted - {1'b0, d_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            n_reg <= req.n;
            d_reg <= req.d;
            r_reg <= 64'd0;
        end else if (busy_reg) begin
            n_reg <= {n_reg[62:0], 1'b0};
            r_reg <= diff[64] ? shifted[63:0] : diff[63:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.r    = r_reg;
endmodule

/* design/sbox_multiply_hash.sv */
`timescale 1ns / 1ps
// Channel   Dir  Handshake              Payload
// s_axis    in   s_tvalid / s_tready    tdata, tuser (mode), tlast (last)
// m_axis    out  m_tvalid / m_tready    tdata (hash_value)
// cfg       in   cfg_we                 cfg_index, cfg_data
// A table load is one RAM write; a full word takes two products on the shared
// multiplier plus eight table reads, one per cycle on the single RAM read port;
// a short word takes two products and three table reads per byte.
// A last word adds two products and the remainder unit, which is skipped with a
// zero table size. Reset is synchronous, active low; tables not cleared.
// A held result in the output register stalls only the next final word.
`include "sbox_multiply_hash_defines.svh"
module sbox_multiply_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // table_address[14:0], table_byte[22:15], data_word[86:23], byte_count[90:87]
    input  logic [95:0] s_tdata,
    // mode
    input  logic        s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // hash_value[63:0]
    output logic [63:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_WMUL  = 5'd1;
    localparam logic [4:0] ST_WMIX  = 5'd2;
    localparam logic [4:0] ST_WRD   = 5'd3;
    localparam logic [4:0] ST_WHMUL = 5'd4;
    localparam logic [4:0] ST_WHEND = 5'd5;
    localparam logic [4:0] ST_BMUL  = 5'd6;
    localparam logic [4:0] ST_BMIX  = 5'd7;
    localparam logic [4:0] ST_BRD   = 5'd8;
    localparam logic [4:0] ST_BHMUL = 5'd9;
    localparam logic [4:0] ST_BHEND = 5'd10;
    localparam logic [4:0] ST_NEXT  = 5'd11;
    localparam logic [4:0] ST_FMUL1 = 5'd12;
    localparam logic [4:0] ST_FMUL2 = 5'd13;
    localparam logic [4:0] ST_FDIV  = 5'd14;
    localparam logic [4:0] ST_OUT   = 5'd15;
    localparam logic [4:0] ST_LOAD  = 5'd16;
    localparam logic [4:0] ST_WFIN  = 5'd17;

    logic [63:0] tsize_reg, phigh_reg, plow_reg, pprod_reg, lmul_reg, shash_reg, seed_reg;
    logic [63:0] hash_reg, mix_reg, total_reg, word_reg, packed_reg, m_reg;
    logic [2:0]  sel_reg;
    logic        inmsg_reg, last_reg;
    logic [3:0]  cnt_reg, k_reg, rd_reg;
    logic [4:0]  state_reg;
    logic        mpend_reg;
    logic        ovalid_reg;
    logic [63:0] odata_reg;

    smh_pkg::mul_req_t mreq;
    smh_pkg::mul_rsp_t mrsp;
    smh_pkg::div_req_t dreq;
    smh_pkg::div_rsp_t drsp;

    logic        ram_we;
    logic [14:0] ram_waddr, ram_raddr;
    logic [7:0]  ram_wdata, ram_rdata;

    smh_mul u_mul (.aclk(aclk), .aresetn(aresetn), .req(mreq), .rsp(mrsp));
    smh_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));
    smh_ram #(.WIDTH(8), .DEPTH(32768)) u_ram (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    wire        s_fire = s_tvalid && s_tready;
    wire [3:0]  in_cnt = s_tdata[90] ? 4'd8 : s_tdata[90:87];
    wire [63:0] start_mix = seed_reg ^ pprod_reg;
    wire [2:0]  sel_inc = sel_reg + 3'd1;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

    assign ram_we    = (state_reg == ST_LOAD);
    assign ram_waddr = word_reg[14:0];
    assign ram_wdata = word_reg[22:15];

    // table index for the current read
    logic [11:0] idx;
    always_comb begin
        idx = 12'd0;
        if (state_reg == ST_WRD) begin
            case (rd_reg)
                4'd0:    idx = m_reg[11:0];
                4'd1:    idx = m_reg[23:12];
                4'd2:    idx = m_reg[35:24];
                4'd3:    idx = m_reg[47:36];
                4'd4:    idx = m_reg[59:48];
                4'd5:    idx = packed_reg[11:0];
                4'd6:    idx = packed_reg[23:12];
                default: idx = packed_reg[35:24];
            endcase
        end else begin
            case (rd_reg)
                4'd0:    idx = mix_reg[11:0] ^ hash_reg[11:0];
                4'd1:    idx = mix_reg[23:12] ^ hash_reg[17:6];
                default: idx = mix_reg[35:24] ^ hash_reg[29:18];
            endcase
        end
    end
    assign ram_raddr = {sel_inc, idx};

    // multiplier start
    always_comb begin
        mreq.start = 1'b0;
        mreq.a = 64'd0;
        mreq.b = 64'd0;
        if (!mpend_reg) begin
            case (state_reg)
                ST_WMUL: begin
                    mreq.start = 1'b1; mreq.a = mix_reg ^ word_reg; mreq.b = plow_reg;
                end
                ST_WHMUL: begin
                    mreq.start = 1'b1; mreq.a = hash_reg; mreq.b = phigh_reg;
                end
                ST_BMUL: begin
                    mreq.start = 1'b1;
                    mreq.a = {mix_reg[55:0], word_reg[7:0]}; mreq.b = plow_reg;
                end
                ST_BHMUL: begin
                    mreq.start = 1'b1; mreq.a = hash_reg; mreq.b = phigh_reg;
                end
                ST_FMUL1: begin
                    mreq.start = 1'b1; mreq.a = total_reg; mreq.b = lmul_reg;
                end
                ST_FMUL2: begin
                    mreq.start = 1'b1; mreq.a = hash_reg; mreq.b = plow_reg;
                end
                default: mreq.start = 1'b0;
            endcase
        end
    end

    assign dreq.start = (state_reg == ST_FDIV) && !mpend_reg;
    assign dreq.n = hash_reg;
    assign dreq.d = tsize_reg;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tsize_reg <= 64'd1; phigh_reg <= 64'd0; plow_reg <= 64'd0;
            pprod_reg <= 64'd0; lmul_reg <= 64'd0; shash_reg <= 64'd0;
            seed_reg <= 64'd0;
        end else if (cfg_we) begin
            case (cfg_index)
                smh_pkg::REG_TABLE_SIZE:  tsize_reg <= cfg_data;
                smh_pkg::REG_PRIME_HIGH:  phigh_reg <= cfg_data;
                smh_pkg::REG_PRIME_LOW:   plow_reg  <= cfg_data;
                smh_pkg::REG_PRIME_PROD:  pprod_reg <= cfg_data;
                smh_pkg::REG_LENGTH_MULT: lmul_reg  <= cfg_data;
                smh_pkg::REG_START_HASH:  shash_reg <= cfg_data;
                smh_pkg::REG_SEED_VALUE:  seed_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mpend_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            inmsg_reg <= 1'b0;
            hash_reg <= 64'd0;
            mix_reg <= 64'd0;
            total_reg <= 64'd0;
            sel_reg <= 3'd0;
            rd_reg <= 4'd0;
        end else begin
            if (ovalid_reg && m_tready) begin
                ovalid_reg <= 1'b0;
            end
            if (mreq.start || dreq.start) begin
                mpend_reg <= 1'b1;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (!s_tuser) begin
                            word_reg <= s_tdata[63:0];
                            state_reg <= ST_LOAD;
                        end else begin
                            word_reg <= s_tdata[86:23];
                            cnt_reg <= in_cnt;
                            last_reg <= s_tlast;
                            k_reg <= 4'd0;
                            rd_reg <= 4'd0;
                            if (!inmsg_reg) begin
                                hash_reg <= shash_reg;
                                mix_reg <= start_mix;
                                sel_reg <= ~start_mix[2:0];
                                total_reg <= 64'd0;
                                inmsg_reg <= 1'b1;
                            end
                            state_reg <= (in_cnt == 4'd8) ? ST_WMUL : ST_NEXT;
                        end
                    end
                end
                ST_LOAD: state_reg <= ST_IDLE;
                ST_WMUL: begin
                    if (mrsp.done) begin
                        mpend_reg <= 1'b0;
                        mix_reg <= mrsp.p ^ (mrsp.p >> 17);
                        state_reg <= ST_WMIX;
                    end
                end
                ST_WMIX: begin
                    m_reg <= mix_reg ^ hash_reg;
                    packed_reg <= (mix_reg << 13) ^ (hash_reg >> 7);
                    state_reg <= ST_WRD;
                end
                ST_WRD: begin
                    // issue read rd_reg, capture read rd_reg-1
                    if (rd_reg < 4'd8) begin
                        sel_reg <= sel_inc;
                    end
                    if (rd_reg != 4'd0) begin
                        hash_reg <= hash_reg ^ ({56'd0, ram_rdata} << (8 * (8 - rd_reg)));
                    end
                    rd_reg <= rd_reg + 4'd1;
                    if (rd_reg == 4'd8) begin
                        state_reg <= ST_WHMUL;
                    end
                end
                ST_WHMUL: begin
                    if (mrsp.done) begin
                        mpend_reg <= 1'b0;
                        hash_reg <= mrsp.p ^ (mrsp.p >> 29);
                        state_reg <= ST_WHEND;
                    end
                end
                ST_WHEND: begin
                    total_reg <= total_reg + 64'd8;
                    state_reg <= last_reg ? ST_FMUL1 : ST_IDLE;
                end
                ST_NEXT: begin
                    if (k_reg == cnt_reg) begin
                        total_reg <= total_reg + {60'd0, cnt_reg};
                        state_reg <= last_reg ? ST_FMUL1 : ST_IDLE;
                    end else begin
                        state_reg <= ST_BMUL;
                    end
                end
                ST_BMUL: begin
                    if (mrsp.done) begin
                        mpend_reg <= 1'b0;
                        mix_reg <= mrsp.p ^ (mrsp.p >> 17);
                        rd_reg <= 4'd0;
                        state_reg <= ST_BRD;
                    end
                end
                ST_BRD: begin
                    if (rd_reg < 4'd3) begin
                        sel_reg <= sel_inc;
                    end
                    if (rd_reg != 4'd0) begin
                        packed_reg <= {packed_reg[55:0], ram_rdata};
                    end
                    rd_reg <= rd_reg + 4'd1;
                    if (rd_reg == 4'd3) begin
                        state_reg <= ST_BMIX;
                    end
                end
                ST_BMIX: begin
                    hash_reg <= {hash_reg[39:0], packed_reg[23:0]} ^ mix_reg;
                    state_reg <= ST_BHMUL;
                end
                ST_BHMUL: begin
                    if (mrsp.done) begin
                        mpend_reg <= 1'b0;
                        hash_reg <= mrsp.p ^ (mrsp.p >> 29);
                        state_reg <= ST_BHEND;
                    end
                end
                ST_BHEND: begin
                    word_reg <= word_reg >> 8;
                    k_reg <= k_reg + 4'd1;
                    state_reg <= ST_NEXT;
                end
                ST_FMUL1: begin
                    if (mrsp.done) begin
                        mpend_reg <= 1'b0;
                        hash_reg <= (hash_reg ^ mrsp.p) ^ ((hash_reg ^ mrsp.p) >> 33);
                        state_reg <= ST_FMUL2;
                    end
                end
                ST_FMUL2: begin
                    if (mrsp.done) begin
                        mpend_reg <= 1'b0;
                        hash_reg <= mrsp.p ^ (mrsp.p >> 27);
                        state_reg <= (tsize_reg != 64'd0) ? ST_FDIV : ST_WFIN;
                    end
                end
                ST_FDIV: begin
                    if (drsp.done) begin
                        mpend_reg <= 1'b0;
                        hash_reg <= drsp.r;
                        state_reg <= ST_WFIN;
                    end
                end
                ST_WFIN: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!ovalid_reg) begin
                        ovalid_reg <= 1'b1;
                        odata_reg <= hash_reg;
                        inmsg_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // hold result stable until taken
    `SMH_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "result changed while stalled")
    // no input taken while busy
    `SMH_ASSERT_IMP(a_busy_block, aclk, aresetn, state_reg != ST_IDLE, !s_tready,
        "input accepted while busy")
    // arithmetic units never started together
    `SMH_ASSERT_IMP(a_one_unit, aclk, aresetn, mreq.start, !dreq.start,
        "two units started at once")
endmodule

/* dv/smh_checker.sv */
`timescale 1ns / 1ps
module smh_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // table_address[14:0], table_byte[22:15], data_word[86:23], byte_count[90:87]
    input  logic [95:0] s_tdata,
    // mode
    input  logic        s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // hash_value[63:0]
    input  logic [63:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          loads_seen,
    output int          words_seen,
    output int          hashes_checked
);
    // shadow copy of the configuration
    logic [63:0] modulus, mul_high, mul_low, mul_prod, len_mult, init_hash, seed;
    // shadow copy of the hashing state
    logic [63:0] acc, mix, total;
    logic [2:0]  sel;
    logic        busy_msg;
    logic [7:0]  sbox [0:32767];
    logic [63:0] hash_q [$];

    // advance the table selector, then read the selected table
    function automatic logic [7:0] sbox_read(logic [63:0] idx);
        sel = sel + 3'd1;
        return sbox[{sel, idx[11:0]}];
    endfunction

    function automatic void fold_full_word(logic [63:0] w);
        logic [63:0] s, m, p;
        s = (mix ^ w) * mul_low;
        s ^= s >> 17;
        mix = s;
        m = s ^ acc;
        p[63:56] = sbox_read(m);
        p[55:48] = sbox_read(m >> 12);
        p[47:40] = sbox_read(m >> 24);
        p[39:32] = sbox_read(m >> 36);
        p[31:24] = sbox_read(m >> 48);
        m = (s << 13) ^ (acc >> 7);
        p[23:16] = sbox_read(m);
        p[15:8]  = sbox_read(m >> 12);
        p[7:0]   = sbox_read(m >> 24);
        acc = (acc ^ p) * mul_high;
        acc ^= acc >> 29;
    endfunction

    function automatic void fold_tail_byte(logic [7:0] b);
        logic [63:0] s, h;
        logic [7:0]  r1, r2, r3;
        s = ((mix << 8) | {56'd0, b}) * mul_low;
        s ^= s >> 17;
        mix = s;
        h = acc;
        r1 = sbox_read(s ^ h);
        r2 = sbox_read((s >> 12) ^ (h >> 6));
        r3 = sbox_read((s >> 24) ^ (h >> 18));
        h = (h << 24) | {40'd0, r1, r2, r3};
        h ^= s;
        h = h * mul_high;
        h ^= h >> 29;
        acc = h;
    endfunction

    // update the shadow state for one transfer and queue any hash it yields
    function automatic void absorb_item(logic [95:0] d, logic md, logic lst);
        logic [63:0] h;
        logic [3:0]  n;
        if (!md) begin
            sbox[d[14:0]] = d[22:15];
            loads_seen++;
            return;
        end
        words_seen++;
        if (!busy_msg) begin
            acc = init_hash;
            mix = seed ^ mul_prod;
            sel = ~mix[2:0];
            total = 64'd0;
            busy_msg = 1'b1;
        end
        n = (d[90:87] > 4'd8) ? 4'd8 : d[90:87];
        if (n == 4'd8)
            fold_full_word(d[86:23]);
        else
            for (int k = 0; k < n; k++)
                fold_tail_byte(d[23 + 8*k +: 8]);
        total += n;
        if (!lst)
            return;
        h = acc ^ (total * len_mult);
        h ^= h >> 33;
        h = h * mul_low;
        h ^= h >> 27;
        if (modulus != 64'd0)
            h = h % modulus;
        acc = h;
        busy_msg = 1'b0;
        hash_q = {hash_q, h};
    endfunction

    function automatic void h_check(logic [63:0] want);
        hashes_checked++;
        if (m_tdata !== want) begin
            $error("hash_value: expected %h, got %h", want, m_tdata);
            fail_count++;
        end
    endfunction

    initial begin
        fail_count = 0;
        pending = 0;
        loads_seen = 0;
        words_seen = 0;
        hashes_checked = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            modulus   = 64'd1;
            mul_high  = 64'd0;
            mul_low   = 64'd0;
            mul_prod  = 64'd0;
            len_mult  = 64'd0;
            init_hash = 64'd0;
            seed      = 64'd0;
            acc       = 64'd0;
            mix       = 64'd0;
            total     = 64'd0;
            sel       = 3'd0;
            busy_msg  = 1'b0;
        end else begin
            // track register writes
            if (cfg_we) begin
                case (cfg_index)
                    smh_pkg::REG_TABLE_SIZE:  modulus   = cfg_data;
                    smh_pkg::REG_PRIME_HIGH:  mul_high  = cfg_data;
                    smh_pkg::REG_PRIME_LOW:   mul_low   = cfg_data;
                    smh_pkg::REG_PRIME_PROD:  mul_prod  = cfg_data;
                    smh_pkg::REG_LENGTH_MULT: len_mult  = cfg_data;
                    smh_pkg::REG_START_HASH:  init_hash = cfg_data;
                    smh_pkg::REG_SEED_VALUE:  seed      = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                absorb_item(s_tdata, s_tuser, s_tlast);
            // compare each result transfer with the oldest predicted hash
            if (m_tvalid && m_tready) begin
                if (hash_q.size() == 0) begin
                    $error("unexpected result transfer, hash_value %h", m_tdata);
                    fail_count++;
                end else begin
                    h_check(hash_q.pop_front());
                end
            end
        end
        pending = hash_q.size();
    end
endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int SETTLE       = 200;
    localparam int PHASE_ITEMS  = 190;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    int fail_count, pending, loads_seen, words_seen, hashes_checked;
    int send_gap = 0;
    int recv_stall = 0;
    int hold_cnt = 0;
    int items_sent = 0;
    int settings = 0;
    int cycles = 0;

    sbox_multiply_hash u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    smh_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .loads_seen(loads_seen),
        .words_seen(words_seen), .hashes_checked(hashes_checked)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // bound the run
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: long hold-off first, otherwise random stalls
    always @(negedge aclk) begin
        if (hold_cnt > 0) begin
            m_tready <= 1'b0;
            hold_cnt--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // offer one item, with random gaps, and hold it until the transfer
    task automatic send_item(logic md, logic [14:0] addr, logic [7:0] tbyte,
                             logic [63:0] word, logic [3:0] cnt, logic lst);
        @(negedge aclk);
        while ($urandom_range(99) < send_gap) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, cnt, word, tbyte, addr};
        s_tuser  <= md;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_load(logic [14:0] addr, logic [7:0] tbyte);
        send_item(1'b0, addr, tbyte, rand64(), 4'($urandom), 1'($urandom));
    endtask

    task automatic send_word(logic [63:0] word, logic [3:0] cnt, logic lst);
        send_item(1'b1, 15'($urandom), 8'($urandom), word, cnt, lst);
    endtask

    // drop valid and wait until every hash is back and the block has settled
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic load_config(logic [63:0] ts, logic [63:0] ph, logic [63:0] pl,
                               logic [63:0] pp, logic [63:0] lm, logic [63:0] sh,
                               logic [63:0] sv);
        write_reg(smh_pkg::REG_TABLE_SIZE, ts);
        write_reg(smh_pkg::REG_PRIME_HIGH, ph);
        write_reg(smh_pkg::REG_PRIME_LOW, pl);
        write_reg(smh_pkg::REG_PRIME_PROD, pp);
        write_reg(smh_pkg::REG_LENGTH_MULT, lm);
        write_reg(smh_pkg::REG_START_HASH, sh);
        write_reg(smh_pkg::REG_SEED_VALUE, sv);
        settings++;
    endtask

    // one well-formed message with random content, sprinkled with table loads
    task automatic send_message(int nwords);
        logic [63:0] word;
        logic [3:0]  cnt;
        for (int i = 0; i < nwords; i++) begin
            if ($urandom_range(99) < 8)
                send_load(15'($urandom), 8'($urandom));
            case ($urandom_range(7))
                0:       word = '0;
                1:       word = '1;
                default: word = rand64();
            endcase
            cnt = 4'd8;
            if (i == nwords - 1)
                cnt = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9))
                                                : 4'($urandom_range(8));
            else if ($urandom_range(99) < 8)
                cnt = 4'($urandom_range(7));
            send_word(word, cnt, i == nwords - 1);
        end
    endtask

    task automatic random_phase(int target);
        int stop_at;
        stop_at = items_sent + target;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 10)
                send_load(15'($urandom), 8'($urandom));
            else
                send_message($urandom_range(1, 5));
        end
        drain();
    endtask

    initial begin
        // hold reset, then fill every table entry so no read hits an unwritten one
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        for (int a = 0; a < 32768; a++)
            send_load(15'(a), 8'($urandom));
        drain();

        // directed messages
        load_config(64'd1000003, rand64() | 64'd1, rand64() | 64'd1, rand64(),
                    rand64(), rand64(), rand64());
        send_word(64'd0, 4'd0, 1'b1);                    // empty message
        send_word(64'd0, 4'd8, 1'b1);
        send_word('1, 4'd8, 1'b1);
        for (int c = 1; c < 8; c++)
            send_word(rand64(), 4'(c), 1'b1);
        send_word(rand64(), 4'd15, 1'b1);               // count above eight
        send_word(rand64(), 4'd9, 1'b1);
        send_word(rand64(), 4'd3, 1'b0);                // short word mid-message
        send_word(rand64(), 4'd8, 1'b0);
        send_load(15'h7FFF, 8'hFF);                     // load during a message
        send_load(15'h0000, 8'h00);
        send_word('1, 4'd8, 1'b1);
        send_word(rand64(), 4'd0, 1'b0);
        send_word(rand64(), 4'd8, 1'b1);
        drain();

        // fill the block while results are held back
        @(posedge aclk);
        hold_cnt = 800;
        for (int i = 0; i < 10; i++)
            send_word(rand64(), 4'($urandom_range(8)), 1'b1);
        drain();

        // random traffic across idling modes and register settings
        for (int m = 0; m < 3; m++) begin
            send_gap   = (m == 0) ? 22 : (m == 1) ? 63 : 0;
            recv_stall = (m == 0) ? 63 : (m == 1) ? 22 : 0;
            for (int j = 0; j < 2; j++) begin
                case (2 * m + j)
                    0: load_config(64'($urandom), rand64() | 64'd1, rand64() | 64'd1,
                                   rand64(), rand64(), rand64(), rand64());
                    1: load_config('1, '1, '1, '1, '1, '1, '1);
                    2: load_config(64'd1, '0, '0, '0, '0, '0, '0);
                    3: load_config(64'd0, rand64(), rand64(), rand64(), rand64(),
                                   rand64(), rand64());
                    4: load_config(rand64() | 64'd1, rand64(), rand64(), rand64(),
                                   rand64(), rand64(), rand64());
                    default: load_config(64'($urandom_range(1, 1000)), rand64(),
                                         rand64(), rand64(), rand64(), rand64(),
                                         rand64());
                endcase
                random_phase(PHASE_ITEMS);
            end
        end

        $display("Run covered %0d table loads and %0d message words under %0d register settings",
                 loads_seen, words_seen, settings);
        $display("%0d hashes compared, %0d mismatches", hashes_checked, fail_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
